/* hdl/scfp_pkg.sv */
// Package for the sum-checked frame parser: phase codes, result kinds,
// register indexes and the state and result structs.
// No dependencies.
`default_nettype none

package scfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned FLEN_W  = 9;
    localparam int unsigned CFG_IDX_W = 8;

    // Head, address, function id, length, sum check, add check
    localparam logic [FLEN_W-1:0] FRAME_OVERHEAD = 9'd6;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_IDX = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_FUNC = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_ADD  = 3'd6
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_GOOD    = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [BYTE_W-1:0]   sum;
        logic [BYTE_W-1:0]   sum_of_sums;
        logic [BYTE_W-1:0]   func;
        logic [BYTE_W-1:0]   len;
        logic [BYTE_W-1:0]   count;
        logic                sum_matched;
    } parse_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   function_id;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   payload_index;
        logic [FLEN_W-1:0]   frame_len;
    } parse_result_t;

endpackage

`default_nettype wire

/* hdl/scfp_step.sv */
// Byte step of the frame parser: next parse state and the result for one
// received byte. Purely combinational; depends on scfp_pkg.
`default_nettype none

module scfp_step (
    input  scfp_pkg::parse_state_t   state,
    input  logic [7:0]               rx_byte,
    input  logic [7:0]               head,
    input  logic [7:0]               addr,
    output scfp_pkg::parse_state_t   state_next,
    output scfp_pkg::parse_result_t  result
);
    import scfp_pkg::*;

    logic [BYTE_W-1:0] sum_acc;
    logic [BYTE_W-1:0] sos_acc;
    logic [BYTE_W-1:0] count_inc;

    assign sum_acc   = state.sum + rx_byte;
    assign sos_acc   = state.sum_of_sums + sum_acc;
    assign count_inc = state.count + 8'd1;

    // Next state
    always_comb
    begin
        state_next = state;
        unique case (state.phase)
            PH_ADDR:
            begin
                if (rx_byte == addr)
                begin
                    state_next.sum         = sum_acc;
                    state_next.sum_of_sums = sos_acc;
                    state_next.phase       = PH_FUNC;
                end
                else
                begin
                    // Mismatch: restart on this byte if it is a head
                    state_next.sum_matched = 1'b0;
                    state_next.sum         = (rx_byte == head) ? rx_byte : '0;
                    state_next.sum_of_sums = (rx_byte == head) ? rx_byte : '0;
                    state_next.phase       = (rx_byte == head) ? PH_ADDR : PH_HUNT;
                end
            end
            PH_FUNC:
            begin
                state_next.func        = rx_byte;
                state_next.sum         = sum_acc;
                state_next.sum_of_sums = sos_acc;
                state_next.phase       = PH_LEN;
            end
            PH_LEN:
            begin
                state_next.len         = rx_byte;
                state_next.count       = '0;
                state_next.sum         = sum_acc;
                state_next.sum_of_sums = sos_acc;
                state_next.phase       = (rx_byte == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                state_next.sum         = sum_acc;
                state_next.sum_of_sums = sos_acc;
                state_next.count       = count_inc;
                if (count_inc == state.len)
                begin
                    state_next.phase = PH_SUM;
                end
            end
            PH_SUM:
            begin
                state_next.sum_matched = (rx_byte == state.sum);
                state_next.phase       = PH_ADD;
            end
            PH_ADD:
            begin
                state_next.sum         = '0;
                state_next.sum_of_sums = '0;
                state_next.sum_matched = 1'b0;
                state_next.phase       = PH_HUNT;
            end
            default:
            begin
                state_next.sum_matched = 1'b0;
                state_next.sum         = (rx_byte == head) ? rx_byte : '0;
                state_next.sum_of_sums = (rx_byte == head) ? rx_byte : '0;
                state_next.phase       = (rx_byte == head) ? PH_ADDR : PH_HUNT;
            end
        endcase
    end

    // Result
    always_comb
    begin
        result = '{kind: KIND_NONE, default: '0};
        unique case (state.phase)
            PH_DATA:
            begin
                result.kind          = KIND_PAYLOAD;
                result.function_id   = state.func;
                result.payload_byte  = rx_byte;
                result.payload_index = state.count;
            end
            PH_ADD:
            begin
                result.kind = (state.sum_matched && rx_byte == state.sum_of_sums)
                              ? KIND_GOOD : KIND_BAD;
                result.function_id = state.func;
                result.frame_len   = {1'b0, state.len} + FRAME_OVERHEAD;
            end
            default:
            begin
                result.kind = KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/sum_checked_frame_parser.sv */
// Top level of the sum-checked frame parser: configuration registers,
// parse state and result register. Depends on scfp_pkg and scfp_step.
`default_nettype none

// Takes one received byte per transfer and returns exactly one result per
// byte from a result register, in the cycle after the byte is taken. A new
// byte is taken in every cycle while results are being taken (rx_ready is
// low only while a result is held and res_ready is low), so the sustained
// rate is one byte per cycle. Payload bytes come out as kind 1; after the
// add check the frame is reported good or bad with its total length. A head
// or address mismatch drops the frame silently and hunts for the next head
// byte. Configuration writes are always taken; indexes other than head (0)
// and address (1) are ignored.
module sum_checked_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data,

    input  logic                            rx_valid,
    output logic                            rx_ready,
    input  logic [7:0]                      rx_byte,

    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      function_id,
    output logic [7:0]                      payload_byte,
    output logic [7:0]                      payload_index,
    output logic [8:0]                      frame_len
);
    import scfp_pkg::*;

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] addr_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    parse_result_t     result_next;
    parse_result_t     result_reg;
    logic              res_valid_reg;
    logic              rx_xfer;

    assign cfg_ready = 1'b1;
    assign rx_ready  = !res_valid_reg || res_ready;
    assign rx_xfer   = rx_valid && rx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            addr_reg <= ADDR_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HEAD_IDX)
            begin
                head_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ADDR_IDX)
            begin
                addr_reg <= cfg_data;
            end
        end
    end

    scfp_step u_step (
        .state      (state_reg),
        .rx_byte    (rx_byte),
        .head       (head_reg),
        .addr       (addr_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_HUNT, default: '0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_xfer)
            begin
                state_reg <= state_next;
            end
            // Hold the result until it is taken
            if (rx_xfer)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = result_reg.kind;
    assign function_id   = result_reg.function_id;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_len     = result_reg.frame_len;

    // Every accepted byte yields a result on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_xfer |=> res_valid)
        else $error("accepted byte produced no result");

    // A non-head byte while hunting keeps the parser hunting
    a_hunt_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_xfer && state_reg.phase == PH_HUNT && rx_byte != head_reg)
        |=> state_reg.phase == PH_HUNT)
        else $error("frame started without head byte");

    // Frame reports always carry at least the fixed overhead length
    a_report_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (kind == KIND_GOOD || kind == KIND_BAD))
        |-> frame_len >= FRAME_OVERHEAD)
        else $error("frame report with short length");

    // Only payload results carry a payload byte or index
    a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind != KIND_PAYLOAD) |-> (payload_byte == '0 && payload_index == '0))
        else $error("payload fields set outside a payload result");

endmodule

`default_nettype wire
